>>> rtl/tfs_pkg.sv
// Shared types, constants and the control store for the telemetry frame stuffer.
`timescale 1ns / 1ps

package tfs_pkg;

    localparam int PC_W = 4;

    localparam logic [7:0] HDR_BYTE  = 8'h10;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_XOR   = 8'h20;
    localparam logic [7:0] CHK_BASE  = 8'hFF;

    typedef struct packed {
        logic [15:0] data_id;
        logic [31:0] data_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       frame_end;
    } t_out_item;

    // Byte source selected by the current control word.
    typedef enum logic [2:0] {
        SEL_HDR = 3'd0,
        SEL_ID0 = 3'd1,
        SEL_ID1 = 3'd2,
        SEL_V0  = 3'd3,
        SEL_V1  = 3'd4,
        SEL_V2  = 3'd5,
        SEL_V3  = 3'd6,
        SEL_CHK = 3'd7
    } t_sel;

    // Branch condition of a control word.
    typedef enum logic [0:0] {
        COND_INPUT  = 1'b0,
        COND_ESCAPE = 1'b1
    } t_cond;

    typedef struct packed {
        logic            emit;
        t_sel            sel;
        logic            last;
        t_cond           cond;
        logic [PC_W-1:0] next;
    } t_ctrl;

    typedef struct packed {
        logic esc_first;
    } t_stat;

    // The program: wait for a record, then one step per frame byte.
    function automatic t_ctrl ctrl_rom(input logic [PC_W-1:0] addr);
        t_ctrl w;
        unique case (addr)
            4'd0:    w = '{1'b0, SEL_HDR, 1'b0, COND_INPUT,  4'd1};
            4'd1:    w = '{1'b1, SEL_HDR, 1'b0, COND_ESCAPE, 4'd2};
            4'd2:    w = '{1'b1, SEL_ID0, 1'b0, COND_ESCAPE, 4'd3};
            4'd3:    w = '{1'b1, SEL_ID1, 1'b0, COND_ESCAPE, 4'd4};
            4'd4:    w = '{1'b1, SEL_V0,  1'b0, COND_ESCAPE, 4'd5};
            4'd5:    w = '{1'b1, SEL_V1,  1'b0, COND_ESCAPE, 4'd6};
            4'd6:    w = '{1'b1, SEL_V2,  1'b0, COND_ESCAPE, 4'd7};
            4'd7:    w = '{1'b1, SEL_V3,  1'b0, COND_ESCAPE, 4'd8};
            4'd8:    w = '{1'b1, SEL_CHK, 1'b1, COND_ESCAPE, 4'd0};
            default: w = '{1'b0, SEL_HDR, 1'b0, COND_INPUT,  4'd0};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/telemetry_frame_stuffer.sv
// Top level of the telemetry frame stuffer: sequencer, datapath and output register.
`timescale 1ns / 1ps
// The first line word enters the output register once the sequencer has left its
// wait step for the header step. A record is stuffed into a frame of 8 to 15 words;
// the microcode steps one word per cycle while the output is not stalled, and
// spends one step waiting for the next record, taking none while a frame is out.
// Reset (i_rst_n low, synchronous) returns the sequencer to its wait step and
// empties the output register; no frame survives reset.

module telemetry_frame_stuffer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tfs_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tfs_pkg::t_out_item o_out_item
);
    import tfs_pkg::*;

    t_ctrl     w_ctrl;
    t_stat     w_stat;
    t_out_item w_word;
    logic      w_accept;
    logic      w_go;
    logic      r_out_valid;
    t_out_item r_out_item;

    // A record is taken only while the program sits on its wait step.
    assign o_in_stall = (w_ctrl.cond != COND_INPUT);
    assign w_accept   = i_in_valid && !o_in_stall;

    // The output register can load whenever it is empty or its word is taken
    // in this cycle, so one word per cycle streams out without bubbles.
    assign w_go = !r_out_valid || !i_out_stall;

    tfs_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_go     (w_go),
        .i_stat   (w_stat),
        .o_ctrl   (w_ctrl)
    );

    tfs_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_go     (w_go),
        .i_item   (i_in_item),
        .i_ctrl   (w_ctrl),
        .o_word   (w_word),
        .o_stat   (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go) begin
            r_out_valid <= w_ctrl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_out_item <= w_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Escaping must keep the flag value off the line entirely.
    a_no_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.line_byte != FLAG_BYTE))
        else $error("flag value reached the line");

    // While the escape half is pending, the output register holds the escape word.
    a_esc_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.emit && !w_stat.esc_first && w_word.line_byte != ESC_BYTE
         && $past(w_stat.esc_first) && $past(w_go) && $past(w_ctrl.emit))
        |-> (o_out_valid && o_out_item.line_byte == ESC_BYTE))
        else $error("escaped word not preceded by escape word");

    // An accepted record makes the program leave its wait step for the header step.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (o_in_stall && w_ctrl.sel == SEL_HDR))
        else $error("record accepted but frame did not start");

    // The final word of a frame returns the program to its wait step.
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && w_ctrl.emit && w_word.frame_end) |=> !o_in_stall)
        else $error("sequencer did not return to wait after frame end");

endmodule

>>> rtl/tfs_seq.sv
// Microcode sequencer: step counter, control store and branch logic.
`timescale 1ns / 1ps

module tfs_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_go,
    input  tfs_pkg::t_stat i_stat,
    output tfs_pkg::t_ctrl o_ctrl
);
    import tfs_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ctrl           w_ctrl;

    assign w_ctrl = ctrl_rom(r_pc);
    assign o_ctrl = w_ctrl;

    // A waiting step advances on a new record; an emit step advances once its
    // byte, including any escaped second half, has gone into the output register.
    always_comb begin
        n_pc = r_pc;
        unique case (w_ctrl.cond)
            COND_INPUT: begin
                if (i_accept) begin
                    n_pc = w_ctrl.next;
                end
            end
            COND_ESCAPE: begin
                if (i_go && !i_stat.esc_first) begin
                    n_pc = w_ctrl.next;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

>>> rtl/tfs_dpath.sv
// Datapath: record register, byte select, escape logic and running checksum.
`timescale 1ns / 1ps

module tfs_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_go,
    input  tfs_pkg::t_in_item i_item,
    input  tfs_pkg::t_ctrl    i_ctrl,
    output tfs_pkg::t_out_item o_word,
    output tfs_pkg::t_stat    o_stat
);
    import tfs_pkg::*;

    t_in_item   r_rec;
    logic [7:0] r_sum;
    logic [7:0] n_sum;
    logic       r_esc;
    logic       n_esc;
    logic [7:0] w_byte;
    logic       w_is_esc;
    logic [8:0] w_add;
    logic       w_step;

    always_comb begin
        unique case (i_ctrl.sel)
            SEL_HDR: w_byte = HDR_BYTE;
            SEL_ID0: w_byte = r_rec.data_id[7:0];
            SEL_ID1: w_byte = r_rec.data_id[15:8];
            SEL_V0:  w_byte = r_rec.data_value[7:0];
            SEL_V1:  w_byte = r_rec.data_value[15:8];
            SEL_V2:  w_byte = r_rec.data_value[23:16];
            SEL_V3:  w_byte = r_rec.data_value[31:24];
            SEL_CHK: w_byte = CHK_BASE - r_sum;
        endcase
    end

    assign w_is_esc         = (w_byte == ESC_BYTE) || (w_byte == FLAG_BYTE);
    assign o_stat.esc_first = w_is_esc && !r_esc;
    assign w_step           = i_go && i_ctrl.emit;

    // End-around carry; a single fold suffices since the sum stays below 0x1FF.
    assign w_add = {1'b0, r_sum} + {1'b0, w_byte};

    always_comb begin
        if (o_stat.esc_first) begin
            o_word.line_byte = ESC_BYTE;
            o_word.frame_end = 1'b0;
        end else begin
            o_word.line_byte = w_is_esc ? (w_byte ^ ESC_XOR) : w_byte;
            o_word.frame_end = i_ctrl.last;
        end
    end

    always_comb begin
        n_sum = r_sum;
        n_esc = r_esc;
        if (i_ctrl.cond == COND_INPUT) begin
            n_sum = '0;
            n_esc = 1'b0;
        end else if (w_step) begin
            if (o_stat.esc_first) begin
                n_esc = 1'b1;
            end else begin
                n_esc = 1'b0;
                n_sum = w_add[7:0] + {7'd0, w_add[8]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= 1'b0;
        end else begin
            r_esc <= n_esc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
        if (i_accept) begin
            r_rec <= i_item;
        end
    end

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the telemetry frame stuffer, with its own frame predictor.
`timescale 1ns / 1ps

module tb_top;
    import tfs_pkg::*;

    // One queued record for the driver. When drain_first is set, the driver
    // holds the record back until every predicted line word has come out.
    typedef struct {
        t_in_item rec;
        bit       drain_first;
    } t_pending;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    t_pending  pending_records[$];
    t_out_item line_words_due[$];
    t_out_item got_word;
    t_out_item want_word;
    int        total_records;
    int        records_taken;
    int        fail_count;
    int        tx_idle_pct;
    int        rx_idle_pct;
    bit        in_taken;

    telemetry_frame_stuffer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    // Adds one byte to the running sum, folding the carry back into bit 0.
    function automatic logic [7:0] sum_fold(input logic [7:0] acc, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, acc} + {1'b0, b};
        s = {1'b0, s[7:0]} + {8'd0, s[8]};
        s = {1'b0, s[7:0]} + {8'd0, s[8]};
        return s[7:0];
    endfunction

    // The checksum byte of a record: all ones minus the folded sum of the
    // header and the six payload bytes, taken before any escaping.
    function automatic logic [7:0] frame_check(input t_in_item r);
        logic [7:0] acc;
        acc = sum_fold(8'd0, HDR_BYTE);
        acc = sum_fold(acc, r.data_id[7:0]);
        acc = sum_fold(acc, r.data_id[15:8]);
        for (int i = 0; i < 4; i++) begin
            acc = sum_fold(acc, r.data_value[8*i +: 8]);
        end
        return CHK_BASE - acc;
    endfunction

    // Queues one frame byte as it goes out on the line. A byte that collides
    // with the escape or flag code becomes the escape byte and then the byte
    // with bit 5 flipped; the frame end mark rides on the last of those.
    function automatic void push_line_byte(input logic [7:0] b, input logic last);
        if (b == ESC_BYTE || b == FLAG_BYTE) begin
            line_words_due.push_back('{line_byte: ESC_BYTE, frame_end: 1'b0});
            line_words_due.push_back('{line_byte: b ^ ESC_XOR, frame_end: last});
        end else begin
            line_words_due.push_back('{line_byte: b, frame_end: last});
        end
    endfunction

    // Predicts every line word of the frame for one accepted record.
    function automatic void predict_frame(input t_in_item r);
        logic [7:0] payload [6];
        payload[0] = r.data_id[7:0];
        payload[1] = r.data_id[15:8];
        for (int i = 0; i < 4; i++) begin
            payload[2 + i] = r.data_value[8*i +: 8];
        end
        push_line_byte(HDR_BYTE, 1'b0);
        for (int i = 0; i < 6; i++) begin
            push_line_byte(payload[i], 1'b0);
        end
        push_line_byte(frame_check(r), 1'b1);
    endfunction

    // Steers the low identifier byte until the checksum lands on the given code,
    // so that the checksum itself has to be escaped.
    function automatic t_in_item force_check(input t_in_item r, input logic [7:0] want);
        t_in_item t;
        t = r;
        for (int v = 0; v < 256; v++) begin
            t.data_id[7:0] = v[7:0];
            if (frame_check(t) == want) begin
                return t;
            end
        end
        return r;
    endfunction

    // Random byte, biased toward the codes that matter for stuffing and for
    // the end-around carry.
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(3) != 0) begin
            return 8'($urandom);
        end
        case ($urandom_range(6))
            0:       return ESC_BYTE;
            1:       return FLAG_BYTE;
            2:       return ESC_BYTE ^ ESC_XOR;
            3:       return FLAG_BYTE ^ ESC_XOR;
            4:       return HDR_BYTE;
            5:       return 8'h00;
            default: return 8'hFF;
        endcase
    endfunction

    function automatic void queue_record(input logic [15:0] id, input logic [31:0] value,
                                         input bit drain);
        t_pending p;
        p.rec.data_id    = id;
        p.rec.data_value = value;
        p.drain_first    = drain;
        pending_records.push_back(p);
    endfunction

    // Driver: inputs change on the falling edge. A record stays on the bus
    // until the rising edge that takes it; only then may valid drop for an
    // idle cycle or move on to the next record.
    always @(negedge i_clk) begin
        case (records_taken * 3 / (total_records > 0 ? total_records : 1))
            0: begin
                tx_idle_pct = 22;
                rx_idle_pct = 58;
            end
            1: begin
                tx_idle_pct = 58;
                rx_idle_pct = 22;
            end
            default: begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
        endcase
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (pending_records.size() != 0
                    && !(pending_records[0].drain_first && line_words_due.size() != 0)
                    && $urandom_range(99) >= tx_idle_pct) begin
                i_in_item  <= pending_records[0].rec;
                i_in_valid <= 1'b1;
                void'(pending_records.pop_front());
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // Monitor: on each rising edge, a record taken in is turned into predicted
    // words first, then a word handed out is checked against the oldest one.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_frame(i_in_item);
                records_taken++;
            end
            if (o_out_valid && !i_out_stall) begin
                got_word = o_out_item;
                if (line_words_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected line word: byte %h end %b",
                                 got_word.line_byte, got_word.frame_end);
                    end
                end else begin
                    want_word = line_words_due.pop_front();
                    if (got_word.line_byte != want_word.line_byte
                            || got_word.frame_end != want_word.frame_end) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("line word differs: want byte %h end %b, got byte %h end %b",
                                     want_word.line_byte, want_word.frame_end,
                                     got_word.line_byte, got_word.frame_end);
                        end
                    end
                end
            end
        end
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
    end

    initial begin
        t_in_item r;
        logic [7:0] b [6];

        // Directed records: field extremes, an escape in every payload position,
        // fully escaped payloads, a checksum that needs escaping, the XOR images
        // of the codes, and sums that wrap through the end-around carry.
        queue_record(16'h0000, 32'h0000_0000, 1'b0);
        queue_record(16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        queue_record(16'h007D, 32'h0000_0000, 1'b0);
        queue_record(16'h7E00, 32'h0000_0000, 1'b0);
        queue_record(16'h0000, 32'h0000_007D, 1'b0);
        queue_record(16'h0000, 32'h0000_7E00, 1'b0);
        queue_record(16'h0000, 32'h007D_0000, 1'b0);
        queue_record(16'h0000, 32'h7E00_0000, 1'b0);
        queue_record(16'h7D7D, 32'h7D7D_7D7D, 1'b0);
        queue_record(16'h7E7E, 32'h7E7E_7E7E, 1'b0);
        queue_record(16'h0072, 32'h0000_0000, 1'b0);
        queue_record(16'h0071, 32'h0000_0000, 1'b1);
        queue_record(16'h5D5E, 32'h5D5E_1010, 1'b0);
        queue_record(16'h8000, 32'h8000_0000, 1'b0);
        queue_record(16'hFFFF, 32'h0000_0000, 1'b0);
        queue_record(16'h0000, 32'hFFFF_FFFF, 1'b0);
        queue_record(16'h1234, 32'h89AB_CDEF, 1'b0);
        r = force_check('{data_id: 16'h7D00, data_value: 32'h7E7E_7D7D}, ESC_BYTE);
        queue_record(r.data_id, r.data_value, 1'b0);
        r = force_check('{data_id: 16'h7E00, data_value: 32'h7D7D_7E7E}, FLAG_BYTE);
        queue_record(r.data_id, r.data_value, 1'b1);

        // Random records with biased bytes; now and then the checksum is
        // steered onto a code that must be escaped, and now and then the
        // sender waits for the line to drain.
        for (int n = 0; n < 480; n++) begin
            for (int i = 0; i < 6; i++) begin
                b[i] = pick_byte();
            end
            r.data_id    = {b[1], b[0]};
            r.data_value = {b[5], b[4], b[3], b[2]};
            if ($urandom_range(7) == 0) begin
                r = force_check(r, $urandom_range(1) ? ESC_BYTE : FLAG_BYTE);
            end
            queue_record(r.data_id, r.data_value,
                         n == 160 || n == 320 || $urandom_range(39) == 0);
        end
        total_records = pending_records.size();

        // Synchronous reset held low from the start, then released on a
        // falling edge like every other input.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_records.size() != 0 || i_in_valid || line_words_due.size() != 0) begin
            @(posedge i_clk);
        end
        // Give the block time to show any stray words past the last frame.
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && line_words_due.size() == 0) begin
            $display("telemetry_frame_stuffer: match");
        end else begin
            $display("telemetry_frame_stuffer: mismatch");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("telemetry_frame_stuffer: mismatch");
        $finish;
    end

endmodule
